### src/assert_macros.svh
// assertion macros used by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/mlrr_pkg.sv
// constants and types of the multilevel round-robin scheduler
`default_nettype none
package mlrr_pkg;

	localparam int MAX_LEVELS  = 8;
	localparam int QUEUE_DEPTH = 16;

	localparam int ID_W     = 22;
	localparam int PRIO_W   = 4;
	localparam int OUT_LVL_W = 3;
	localparam int TICK_W   = 16;
	localparam int STATUS_W = 2;

	localparam int LVL_W   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ACT_W   = $clog2(MAX_LEVELS + 1);

	localparam int STORE_DEPTH = MAX_LEVELS * QUEUE_DEPTH;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam int LEVELS_W  = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEVELS  = 1'b0,
		REG_QUANTUM = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_BAD_PRIO = 2'd2
	} status_t;

endpackage
`default_nettype wire

### src/mlrr_req_if.sv
// request channel: one add or tick beat
`default_nettype none
interface mlrr_req_if;
	import mlrr_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [ID_W-1:0]   task_id;
	logic [PRIO_W-1:0] priority_req;
	logic              done_req;

	modport source (output valid, output operation, output task_id,
		output priority_req, output done_req, input ready);
	modport sink (input valid, input operation, input task_id,
		input priority_req, input done_req, output ready);
endinterface
`default_nettype wire

### src/mlrr_res_if.sv
// result channel: one scheduling result beat
`default_nettype none
interface mlrr_res_if;
	import mlrr_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 dispatch_valid;
	logic [ID_W-1:0]      dispatch_id;
	logic [OUT_LVL_W-1:0] dispatch_level;
	logic                 retire_valid;
	logic [ID_W-1:0]      retire_id;
	logic                 busy_res;
	logic [STATUS_W-1:0]  status;

	modport source (output valid, output dispatch_valid, output dispatch_id,
		output dispatch_level, output retire_valid, output retire_id,
		output busy_res, output status, input ready);
	modport sink (input valid, input dispatch_valid, input dispatch_id,
		input dispatch_level, input retire_valid, input retire_id,
		input busy_res, input status, output ready);
endinterface
`default_nettype wire

### src/multilevel_round_robin_scheduler.sv
// Multilevel round-robin scheduler: one task FIFO per priority level, all held
// in a single-port task store ram; head, tail and fill count per level sit in
// flops. An item that dispatches a task passes from the accepting edge through
// the states EXEC (queue write), DISP (head read), RDATA (read data) and DONE
// (result load). When a dispatch is tried but every active level is empty, RDATA
// is skipped; when no dispatch is tried, DISP is skipped as well. The result load
// waits while the previous beat is still held. After the result load the block
// returns to idle and takes the next item. The single ram port is used once for
// the queue write and once for the head read, in separate states. The result sits
// in an output register, so the next item is taken while the last beat waits.
// Levels beyond the configured level count keep their tasks.
`default_nettype none
`include "assert_macros.svh"
module multilevel_round_robin_scheduler (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	mlrr_req_if.sink                           req,
	mlrr_res_if.source                         res,
	input  wire logic                          cfg_we,
	input  wire logic [mlrr_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [mlrr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mlrr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DISP,
		S_RDATA,
		S_DONE
	} state_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
		else r = p + PTR_W'(1);
		return r;
	endfunction

	function automatic logic [STORE_AW-1:0] store_addr(input logic [LVL_W-1:0] l,
		input logic [PTR_W-1:0] p);
		return STORE_AW'(STORE_AW'(l) * STORE_AW'(QUEUE_DEPTH)) + STORE_AW'(p);
	endfunction

	state_t state_q;

	logic [LEVELS_W-1:0] levels_q;
	logic [TICK_W-1:0]   quantum_q;

	logic                op_q;
	logic [ID_W-1:0]     id_q;
	logic [PRIO_W-1:0]   prio_q;
	logic                done_q;

	logic [CNT_W-1:0]    cnt_q  [MAX_LEVELS];
	logic [PTR_W-1:0]    head_q [MAX_LEVELS];
	logic [PTR_W-1:0]    tail_q [MAX_LEVELS];

	logic                running_q;
	logic [ID_W-1:0]     run_id_q;
	logic [LVL_W-1:0]    run_lvl_q;
	logic [TICK_W-1:0]   tick_q;

	logic                disp_q;
	logic                retire_q;
	logic [ID_W-1:0]     ret_id_q;
	status_t             status_q;

	logic                 res_valid_q;
	logic                 res_disp_q;
	logic [ID_W-1:0]      res_disp_id_q;
	logic [OUT_LVL_W-1:0] res_disp_lvl_q;
	logic                 res_retire_q;
	logic [ID_W-1:0]      res_retire_id_q;
	logic                 res_busy_q;
	status_t              res_status_q;

	logic [ACT_W-1:0]    act;
	logic                prio_bad;
	logic [LVL_W-1:0]    push_lvl;
	logic [ID_W-1:0]     push_id;
	logic                push_ok;
	logic [TICK_W:0]     tick_next;
	logic [TICK_W-1:0]   q_eff;
	logic                q_end;
	logic                exec_push;
	logic                exec_disp;
	logic                exec_retire;
	status_t             exec_status;
	logic                found;
	logic [LVL_W-1:0]    find_lvl;
	logic                accept;
	logic                load_res;

	logic                ram_we;
	logic [STORE_AW-1:0] ram_addr;
	logic [ID_W-1:0]     ram_rdata;

	always_comb begin
		if (levels_q == '0) act = ACT_W'(1);
		else if (32'(levels_q) > MAX_LEVELS) act = ACT_W'(MAX_LEVELS);
		else act = ACT_W'(levels_q);

		prio_bad = (prio_q == '0) || (32'(prio_q) > 32'(act));
		push_lvl = (op_q == OP_ADD) ? LVL_W'(prio_q - PRIO_W'(1)) : run_lvl_q;
		push_id  = (op_q == OP_ADD) ? id_q : run_id_q;
		push_ok  = 32'(cnt_q[push_lvl]) < QUEUE_DEPTH;

		q_eff     = (quantum_q == '0) ? TICK_W'(1) : quantum_q;
		tick_next = {1'b0, tick_q} + (TICK_W+1)'(1);
		q_end     = tick_next >= {1'b0, q_eff};

		exec_push   = 1'b0;
		exec_disp   = 1'b0;
		exec_retire = 1'b0;
		exec_status = STAT_OK;
		if (op_q == OP_ADD) begin
			if (prio_bad) exec_status = STAT_BAD_PRIO;
			else if (!push_ok) exec_status = STAT_FULL;
			else exec_push = 1'b1;
			exec_disp = !running_q;
		end else if (running_q) begin
			if (q_end) begin
				exec_disp = 1'b1;
				if (done_q) exec_retire = 1'b1;
				else if (push_ok) exec_push = 1'b1;
				else exec_status = STAT_FULL;
			end
		end else begin
			exec_disp = 1'b1;
		end

		found    = 1'b0;
		find_lvl = '0;
		for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0 && i < 32'(act)) begin
				found    = 1'b1;
				find_lvl = LVL_W'(i);
			end
		end

		ram_we   = (state_q == S_EXEC) && exec_push;
		if (state_q == S_EXEC) ram_addr = store_addr(push_lvl, tail_q[push_lvl]);
		else ram_addr = store_addr(find_lvl, head_q[find_lvl]);
	end

	assign accept   = req.valid && req.ready;
	assign load_res = (state_q == S_DONE) && (!res_valid_q || res.ready);

	mlrr_ram #(
		.WIDTH (ID_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (push_id),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			levels_q        <= LEVELS_W'(MAX_LEVELS);
			quantum_q       <= TICK_W'(4);
			op_q            <= OP_ADD;
			id_q            <= '0;
			prio_q          <= '0;
			done_q          <= 1'b0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			running_q       <= 1'b0;
			run_id_q        <= '0;
			run_lvl_q       <= '0;
			tick_q          <= '0;
			disp_q          <= 1'b0;
			retire_q        <= 1'b0;
			ret_id_q        <= '0;
			status_q        <= STAT_OK;
			res_valid_q     <= 1'b0;
			res_disp_q      <= 1'b0;
			res_disp_id_q   <= '0;
			res_disp_lvl_q  <= '0;
			res_retire_q    <= 1'b0;
			res_retire_id_q <= '0;
			res_busy_q      <= 1'b0;
			res_status_q    <= STAT_OK;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LEVELS:  levels_q  <= LEVELS_W'(cfg_wdata);
					REG_QUANTUM: quantum_q <= TICK_W'(cfg_wdata);
					default: ;
				endcase
			end

			if (res_valid_q && res.ready && !load_res) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= req.operation;
						id_q     <= req.task_id;
						prio_q   <= req.priority_req;
						done_q   <= req.done_req;
						disp_q   <= 1'b0;
						retire_q <= 1'b0;
						ret_id_q <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= exec_status;
					if (exec_push) begin
						tail_q[push_lvl] <= ptr_inc(tail_q[push_lvl]);
						cnt_q[push_lvl]  <= cnt_q[push_lvl] + CNT_W'(1);
					end
					if (op_q == OP_TICK && running_q) begin
						if (q_end) begin
							running_q <= 1'b0;
							tick_q    <= '0;
						end else begin
							tick_q <= TICK_W'(tick_next);
						end
					end
					if (exec_retire) begin
						retire_q <= 1'b1;
						ret_id_q <= run_id_q;
					end
					state_q <= exec_disp ? S_DISP : S_DONE;
				end
				S_DISP: begin
					if (found) begin
						head_q[find_lvl] <= ptr_inc(head_q[find_lvl]);
						cnt_q[find_lvl]  <= cnt_q[find_lvl] - CNT_W'(1);
						run_lvl_q        <= find_lvl;
						running_q        <= 1'b1;
						tick_q           <= '0;
						disp_q           <= 1'b1;
						state_q          <= S_RDATA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RDATA: begin
					run_id_q <= ram_rdata;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (load_res) begin
						res_valid_q     <= 1'b1;
						res_disp_q      <= disp_q;
						res_disp_id_q   <= disp_q ? run_id_q : '0;
						res_disp_lvl_q  <= disp_q ? OUT_LVL_W'(run_lvl_q) : '0;
						res_retire_q    <= retire_q;
						res_retire_id_q <= retire_q ? ret_id_q : '0;
						res_busy_q      <= running_q;
						res_status_q    <= status_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign res.valid          = res_valid_q;
	assign res.dispatch_valid = res_disp_q;
	assign res.dispatch_id    = res_disp_id_q;
	assign res.dispatch_level = res_disp_lvl_q;
	assign res.retire_valid   = res_retire_q;
	assign res.retire_id      = res_retire_id_q;
	assign res.busy_res       = res_busy_q;
	assign res.status         = res_status_q;

	// one item in flight: no new beat right after an accept
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, accept, !req.ready)
	// a dispatched task is running once the result is loaded
	`ASSERT_NEXT(a_disp_busy, clk, arst_n, load_res && disp_q, res_busy_q && res_valid_q)
	// retirement only comes from a tick with done set
	`ASSERT_SAME(a_retire_tick, clk, arst_n, load_res && retire_q,
		op_q == OP_TICK && done_q && status_q == STAT_OK)
endmodule
`default_nettype wire

### src/mlrr_ram.sv
// generic single-port ram with registered read
`default_nettype none
module mlrr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### bench/testbench.sv
// self-checking testbench of the multilevel round-robin scheduler
`default_nettype none
module testbench;
	import mlrr_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		op_t               op;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic              done;
	} sched_item_t;

	typedef struct packed {
		logic                 disp_v;
		logic [ID_W-1:0]      disp_id;
		logic [OUT_LVL_W-1:0] disp_lvl;
		logic                 ret_v;
		logic [ID_W-1:0]      ret_id;
		logic                 busy;
		status_t              status;
	} sched_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	mlrr_req_if req_ch ();
	mlrr_res_if res_ch ();

	multilevel_round_robin_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// scheduler mirror
	logic [LEVELS_W-1:0] lvl_cfg = 4'd8;
	logic [TICK_W-1:0] qnt_cfg = 16'd4;
	logic [ID_W-1:0] lvl_store [MAX_LEVELS][QUEUE_DEPTH];
	int lvl_head [MAX_LEVELS] = '{default: 0};
	int lvl_tail [MAX_LEVELS] = '{default: 0};
	int lvl_fill [MAX_LEVELS] = '{default: 0};
	logic run_busy = 1'b0;
	logic [ID_W-1:0] run_id = '0;
	int run_lvl = 0;
	int run_ticks = 0;

	sched_item_t backlog [$];
	sched_result_t due [$];

	logic steady = 1'b0;
	int errors = 0;
	int stall = 0;
	int n_items = 0;
	int n_disp = 0;
	int n_ret = 0;
	int n_full = 0;
	int n_bad = 0;
	int n_phases = 0;

	function automatic int active_count();
		if (lvl_cfg == 0)
			return 1;
		if (lvl_cfg > MAX_LEVELS)
			return MAX_LEVELS;
		return int'(lvl_cfg);
	endfunction

	function automatic logic enqueue(int lvl, logic [ID_W-1:0] id);
		if (lvl_fill[lvl] >= QUEUE_DEPTH)
			return 1'b0;
		lvl_store[lvl][lvl_tail[lvl]] = id;
		lvl_tail[lvl] = (lvl_tail[lvl] + 1) % QUEUE_DEPTH;
		lvl_fill[lvl]++;
		return 1'b1;
	endfunction

	function automatic logic pick_next();
		for (int l = 0; l < active_count(); l++) begin
			if (lvl_fill[l] != 0) begin
				run_id = lvl_store[l][lvl_head[l]];
				lvl_head[l] = (lvl_head[l] + 1) % QUEUE_DEPTH;
				lvl_fill[l]--;
				run_lvl = l;
				run_busy = 1'b1;
				run_ticks = 0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void schedule_step(sched_item_t it);
		sched_result_t r;
		int q;
		r = '0;
		r.status = STAT_OK;
		if (it.op == OP_ADD) begin
			if (it.prio == 0 || it.prio > active_count())
				r.status = STAT_BAD_PRIO;
			else if (!enqueue(int'(it.prio) - 1, it.id))
				r.status = STAT_FULL;
			if (!run_busy)
				r.disp_v = pick_next();
		end else if (run_busy) begin
			q = (qnt_cfg == 0) ? 1 : int'(qnt_cfg);
			if (run_ticks + 1 >= q) begin
				run_busy = 1'b0;
				run_ticks = 0;
				if (it.done) begin
					r.ret_v = 1'b1;
					r.ret_id = run_id;
				end else if (!enqueue(run_lvl, run_id)) begin
					r.status = STAT_FULL;
				end
				r.disp_v = pick_next();
			end else begin
				run_ticks = run_ticks + 1;
			end
		end else begin
			r.disp_v = pick_next();
		end
		if (r.disp_v) begin
			r.disp_id = run_id;
			r.disp_lvl = run_lvl[OUT_LVL_W-1:0];
		end
		r.busy = run_busy;
		n_items++;
		n_disp += r.disp_v;
		n_ret += r.ret_v;
		n_full += (r.status == STAT_FULL);
		n_bad += (r.status == STAT_BAD_PRIO);
		due.push_back(r);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic go;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.operation <= OP_ADD;
			req_ch.task_id <= '0;
			req_ch.priority_req <= '0;
			req_ch.done_req <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				schedule_step(backlog.pop_front());
			if (!req_ch.valid || req_ch.ready) begin
				go = backlog.size() != 0 && (steady || $urandom_range(99) >= 37);
				req_ch.valid <= go;
				if (go) begin
					req_ch.operation <= backlog[0].op;
					req_ch.task_id <= backlog[0].id;
					req_ch.priority_req <= backlog[0].prio;
					req_ch.done_req <= backlog[0].done;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : check_proc
		sched_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (due.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = due.pop_front();
					check_field("dispatch_valid", 32'(want.disp_v),
						32'(res_ch.dispatch_valid));
					check_field("dispatch_id", 32'(want.disp_id), 32'(res_ch.dispatch_id));
					check_field("dispatch_level", 32'(want.disp_lvl),
						32'(res_ch.dispatch_level));
					check_field("retire_valid", 32'(want.ret_v), 32'(res_ch.retire_valid));
					check_field("retire_id", 32'(want.ret_id), 32'(res_ch.retire_id));
					check_field("busy_res", 32'(want.busy), 32'(res_ch.busy_res));
					check_field("status", 32'(want.status), 32'(res_ch.status));
				end
			end
			res_ch.ready <= steady || $urandom_range(99) >= 37;
		end
	end

	// watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				stall <= 0;
			else
				stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic push_item(op_t op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
			logic done);
		sched_item_t it;
		it.op = op;
		it.id = id;
		it.prio = prio;
		it.done = done;
		backlog.push_back(it);
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (backlog.size() != 0 || due.size() != 0 || req_ch.valid);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= v;
		if (idx == REG_LEVELS)
			lvl_cfg = v[LEVELS_W-1:0];
		else
			qnt_cfg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(int n, int add_pct);
		logic [PRIO_W-1:0] prio;
		int act;
		act = active_count();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < add_pct) begin
				if ($urandom_range(99) < 88) begin
					prio = PRIO_W'($urandom_range(act, 1));
				end else begin
					prio = PRIO_W'($urandom_range(15 - act, 0));
					if (prio != 0)
						prio = prio + PRIO_W'(act);
				end
				push_item(OP_ADD, ID_W'($urandom()), prio, 1'($urandom_range(1, 0)));
			end else begin
				push_item(OP_TICK, ID_W'($urandom()), PRIO_W'($urandom()),
					$urandom_range(99) < 40);
			end
		end
	endtask

	task automatic run_phase(int n, int add_pct, logic [CFG_DATA_W-1:0] lv,
			logic [CFG_DATA_W-1:0] qn, logic no_idle);
		set_reg(REG_LEVELS, lv);
		set_reg(REG_QUANTUM, qn);
		steady = no_idle;
		n_phases++;
		random_items(n / 2, add_pct);
		// sender holds off until every result is back
		drain();
		random_items(n - n / 2, add_pct);
		drain();
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_LEVELS;
		cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle, adds, bad priorities, requeue and retire
		push_item(OP_TICK, 22'h000000, 4'd0, 1'b1);
		push_item(OP_ADD, 22'h000000, 4'd1, 1'b0);
		push_item(OP_ADD, 22'h3FFFFF, 4'd8, 1'b1);
		push_item(OP_ADD, 22'h155555, 4'd0, 1'b0);
		push_item(OP_ADD, 22'h2AAAAA, 4'd9, 1'b0);
		push_item(OP_ADD, 22'h2AAAAA, 4'd15, 1'b1);
		repeat (4) push_item(OP_TICK, ID_W'($urandom()), 4'd0, 1'b0);
		repeat (3) push_item(OP_TICK, ID_W'($urandom()), 4'd0, 1'b0);
		push_item(OP_TICK, 22'h000000, 4'd0, 1'b1);
		// running task from a level that gets hidden
		set_reg(REG_LEVELS, 16'd2);
		repeat (4) push_item(OP_TICK, 22'h000000, 4'd0, 1'b0);
		push_item(OP_ADD, 22'h0F0F0F, 4'd3, 1'b0);
		// idle with waiting tasks, dropped add still dispatches
		set_reg(REG_LEVELS, 16'd15);
		push_item(OP_ADD, 22'h123456, 4'd0, 1'b0);
		set_reg(REG_QUANTUM, 16'd0);
		push_item(OP_TICK, 22'h000000, 4'd0, 1'b1);
		// quantum lowered below the running count
		set_reg(REG_QUANTUM, 16'hFFFF);
		push_item(OP_ADD, 22'h0ABCDE, 4'd2, 1'b0);
		repeat (3) push_item(OP_TICK, 22'h000000, 4'd0, 1'b1);
		set_reg(REG_QUANTUM, 16'd2);
		push_item(OP_TICK, 22'h000000, 4'd0, 1'b0);
		set_reg(REG_LEVELS, 16'd0);
		push_item(OP_ADD, 22'h200001, 4'd2, 1'b0);
		repeat (2) push_item(OP_TICK, 22'h000000, 4'd0, 1'b1);
		drain();
		n_phases++;

		run_phase(250, 50, 16'd8, 16'd4, 1'b0);
		run_phase(200, 70, 16'd1, 16'd1, 1'b0);
		run_phase(80, 60, 16'd2, 16'hFFFF, 1'b0);
		run_phase(250, 45, 16'd3, 16'd2, 1'b1);
		run_phase(150, 50, 16'd0, 16'd0, 1'b0);
		run_phase(250, 40, 16'd15, 16'd3, 1'b0);
		run_phase(270, 50, 16'd5, 16'd7, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		if (due.size() != 0) begin
			$error("%0d results never arrived", due.size());
			errors++;
		end
		$display("%0d items over %0d register settings: %0d dispatched, %0d retired",
			n_items, n_phases, n_disp, n_ret);
		$display("%0d dropped on a full level, %0d with a bad priority, %0d errors",
			n_full, n_bad, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
